// ===== design/rtpjla_pkg.sv =====
// Shared types, register map and constants of the RTP jitter latency adapter.
`timescale 1ns / 1ps

package rtpjla_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int CFG_ADDR_W        = 5;
  localparam int SUM_W             = 36;
  localparam int DEN_W             = 7;

  localparam int MS_DIVISOR  = 1000;
  localparam int MS_ROUND    = 500;
  localparam int IA_DIVISOR  = 10;
  localparam int IA_HALF     = 5;
  localparam int JIT_DIVISOR = 5;
  localparam int JIT_HALF    = 2;

  // The millisecond conversion divides by 1000 as a shift by three and a divide by 125.
  localparam int MS_SHIFT      = 3;
  localparam int MS_STEP_DIV   = MS_DIVISOR >> MS_SHIFT;
  localparam int MS_STEP_ROUND = MS_ROUND >> MS_SHIFT;

  localparam logic [31:0] MS_STEP_RECIP = 32'((64'd1 << 32) / MS_STEP_DIV);
  localparam logic [31:0] IA_RECIP      = 32'((64'd1 << 32) / IA_DIVISOR);
  localparam logic [31:0] JIT_RECIP     = 32'((64'd1 << 32) / JIT_DIVISOR);

  localparam logic [7:0] AUDIO_TYPE   = 8'h02;
  localparam logic [1:0] RTP_VERSION  = 2'b10;
  localparam int         MIN_LENGTH   = 2;
  localparam int         TS_LENGTH    = 21;
  localparam int         RTP_LENGTH   = 13;

  localparam logic [9:0]  MIN_LAT_RST   = 10'd50;
  localparam logic [9:0]  MAX_LAT_RST   = 10'd300;
  localparam logic [9:0]  BASE_LAT_RST  = 10'd50;
  localparam logic [9:0]  THRESHOLD_RST = 10'd10;
  localparam logic [15:0] INTERVAL_RST  = 16'd1000;
  localparam logic [9:0]  INIT_LAT_RST  = 10'd100;

  typedef enum logic [2:0] {
    REG_MIN      = 3'd0,
    REG_MAX      = 3'd1,
    REG_BASE     = 3'd2,
    REG_THRESH   = 3'd3,
    REG_INTERVAL = 3'd4,
    REG_INIT     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_TYPE  = 2'd2,
    ST_RTP   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DIV_MS,
    DIV_IA,
    DIV_JIT
  } div_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT_SPLIT,
    S_WAIT_DELTA,
    S_IA_PREP,
    S_WAIT_IA,
    S_DEV_PREP,
    S_WAIT_JIT,
    S_ADJ_SUM,
    S_ADJ_CLAMP,
    S_ADJ_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       start;
    div_op_t    op;
  } div_req_t;

  typedef struct packed {
    logic [9:0]  min_lat;
    logic [9:0]  max_lat;
    logic [9:0]  base_lat;
    logic [9:0]  threshold;
    logic [15:0] interval;
    logic [9:0]  init_lat;
    logic        init_load;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  ninth_byte;
    logic [63:0] header_bytes;
    logic [7:0]  type_byte;
    logic [15:0] packet_length;
    logic [31:0] arrival_time_us;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        capture_valid;
    logic [63:0] capture_timestamp_us;
    logic [9:0]  latency_ms;
    logic        latency_changed;
    logic [31:0] jitter_estimate;
  } res_t;

endpackage

// ===== design/rtpjla_cfg.sv =====
// APB-style register file holding the latency adapter configuration.
`timescale 1ns / 1ps

module rtpjla_cfg import rtpjla_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic [9:0]  min_r, min_nxt;
  logic [9:0]  max_r, max_nxt;
  logic [9:0]  base_r, base_nxt;
  logic [9:0]  thr_r, thr_nxt;
  logic [15:0] intv_r, intv_nxt;
  logic [9:0]  init_r, init_nxt;
  logic        wr;
  reg_idx_t    idx;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = reg_idx_t'(cfg_paddr[4:2]);

  always_comb begin
    min_nxt  = min_r;
    max_nxt  = max_r;
    base_nxt = base_r;
    thr_nxt  = thr_r;
    intv_nxt = intv_r;
    init_nxt = init_r;
    if (wr) begin
      unique case (idx)
        REG_MIN:      min_nxt  = cfg_pwdata[9:0];
        REG_MAX:      max_nxt  = cfg_pwdata[9:0];
        REG_BASE:     base_nxt = cfg_pwdata[9:0];
        REG_THRESH:   thr_nxt  = cfg_pwdata[9:0];
        REG_INTERVAL: intv_nxt = cfg_pwdata[15:0];
        REG_INIT:     init_nxt = cfg_pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MIN_LAT_RST;
      max_r  <= MAX_LAT_RST;
      base_r <= BASE_LAT_RST;
      thr_r  <= THRESHOLD_RST;
      intv_r <= INTERVAL_RST;
      init_r <= INIT_LAT_RST;
    end else begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      base_r <= base_nxt;
      thr_r  <= thr_nxt;
      intv_r <= intv_nxt;
      init_r <= init_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN:      cfg_prdata = {22'd0, min_r};
      REG_MAX:      cfg_prdata = {22'd0, max_r};
      REG_BASE:     cfg_prdata = {22'd0, base_r};
      REG_THRESH:   cfg_prdata = {22'd0, thr_r};
      REG_INTERVAL: cfg_prdata = {16'd0, intv_r};
      REG_INIT:     cfg_prdata = {22'd0, init_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.min_lat   = min_r;
  assign cfg.max_lat   = max_r;
  assign cfg.base_lat  = base_r;
  assign cfg.threshold = thr_r;
  assign cfg.interval  = intv_r;
  assign cfg.init_lat  = cfg_pwdata[9:0];
  assign cfg.init_load = wr && (idx == REG_INIT);

endmodule

// ===== design/rtpjla_div.sv =====
// Shared divider by a small constant using a reciprocal multiply and one correction step.
`timescale 1ns / 1ps

module rtpjla_div import rtpjla_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [31:0]      num,
  output logic             done,
  output logic [31:0]      quot,
  output logic [DEN_W-1:0] rem
);

  logic [31:0]      x_r, x_nxt;
  logic [31:0]      recip_r, recip_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [31:0]      q0_r, q0_nxt;
  logic [31:0]      quot_r, quot_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic             mul_r, mul_nxt;
  logic             fix_r, fix_nxt;
  logic             done_r, done_nxt;
  logic [63:0]      prod;
  logic [31:0]      r0;
  logic [31:0]      r1;
  logic             ge;
  logic [DEN_W-1:0] den_sel;
  logic [31:0]      recip_sel;

  always_comb begin
    unique case (req.op)
      DIV_MS: begin
        den_sel   = DEN_W'(MS_STEP_DIV);
        recip_sel = MS_STEP_RECIP;
      end
      DIV_IA: begin
        den_sel   = DEN_W'(IA_DIVISOR);
        recip_sel = IA_RECIP;
      end
      default: begin
        den_sel   = DEN_W'(JIT_DIVISOR);
        recip_sel = JIT_RECIP;
      end
    endcase
  end

  // The reciprocal is rounded down, so the first quotient is low by at most one.
  assign prod = {32'd0, x_r} * {32'd0, recip_r};
  assign r0   = x_r - q0_r * 32'(den_r);
  assign ge   = r0 >= 32'(den_r);
  assign r1   = ge ? r0 - 32'(den_r) : r0;

  always_comb begin
    x_nxt     = x_r;
    recip_nxt = recip_r;
    den_nxt   = den_r;
    q0_nxt    = q0_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    mul_nxt   = 1'b0;
    fix_nxt   = 1'b0;
    done_nxt  = 1'b0;
    if (req.start) begin
      x_nxt     = num;
      recip_nxt = recip_sel;
      den_nxt   = den_sel;
      mul_nxt   = 1'b1;
    end
    if (mul_r) begin
      q0_nxt  = prod[63:32];
      fix_nxt = 1'b1;
    end
    if (fix_r) begin
      quot_nxt = ge ? q0_r + 32'd1 : q0_r;
      rem_nxt  = r1[DEN_W-1:0];
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= mul_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    recip_r <= recip_nxt;
    den_r   <= den_nxt;
    q0_r    <= q0_nxt;
    quot_r  <= quot_nxt;
    rem_r   <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ===== design/rtpjla_ctrl.sv =====
// Sequencer and state of the adapter: header checks, averages and latency target.
`timescale 1ns / 1ps

module rtpjla_ctrl import rtpjla_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     res_ready,
  output logic     res_valid,
  output res_t     res
);

  localparam int TW          = SUM_W - FRACTION_BITS;
  localparam int SPLIT_SHIFT = FRACTION_BITS - MS_SHIFT;
  localparam logic [63:0] SAT_US = ((64'(MS_DIVISOR) << 32) - 64'(MS_ROUND) +
                                    (64'd1 << FRACTION_BITS) - 64'd1) >> FRACTION_BITS;

  state_t      state_r, state_nxt;
  in_item_t    item_r, item_nxt;
  status_t     status_r, status_nxt;
  logic        cap_r, cap_nxt;
  logic        changed_r, changed_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] last_arr_r, last_arr_nxt;
  logic [31:0] ia_r, ia_nxt;
  logic [31:0] jit_r, jit_nxt;
  logic [9:0]  cur_lat_r, cur_lat_nxt;
  logic [31:0] last_adj_r, last_adj_nxt;
  logic [63:0] capture_r, capture_nxt;
  logic [31:0] delta_r, delta_nxt;
  logic        up_r, up_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [9:0]  target_r, target_nxt;

  status_t     chk_status;
  logic        chk_cap;
  logic [31:0] dus;
  logic        dus_sat;
  logic [31:0] ia_diff;
  logic        ia_round;
  logic [31:0] ia_mag;
  logic [31:0] dev;
  logic [31:0] jit_diff;
  logic        jit_round;
  logic [31:0] jit_mag;
  logic [31:0] elapsed;
  logic [31:0] interval_us;
  logic [SUM_W-1:0] sum_calc;
  logic [TW-1:0] tgt_raw;
  logic [TW-1:0] tgt_lo;
  logic [TW-1:0] tgt_clamp;
  logic [9:0]  lat_diff;

  div_req_t         div_req;
  logic [31:0]      div_num;
  logic             div_done;
  logic [31:0]      div_quot;
  logic [DEN_W-1:0] div_rem;

  rtpjla_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_comb begin
    chk_cap = 1'b0;
    if (item_r.packet_length < 16'(MIN_LENGTH)) begin
      chk_status = ST_SHORT;
    end else if (item_r.type_byte != AUDIO_TYPE) begin
      chk_status = ST_TYPE;
    end else if (item_r.packet_length >= 16'(TS_LENGTH) &&
                 item_r.ninth_byte[7:6] == RTP_VERSION) begin
      chk_status = ST_OK;
      chk_cap    = 1'b1;
    end else if (item_r.packet_length < 16'(RTP_LENGTH)) begin
      chk_status = ST_SHORT;
    end else if (item_r.header_bytes[63:62] != RTP_VERSION) begin
      chk_status = ST_RTP;
    end else begin
      chk_status = ST_OK;
    end
  end

  assign dus       = item_r.arrival_time_us - last_arr_r;
  assign dus_sat   = {32'd0, dus} >= SAT_US;
  assign ia_diff   = (delta_r >= ia_r) ? delta_r - ia_r : ia_r - delta_r;
  assign ia_round  = (32'(div_rem) + 32'(IA_HALF)) >= 32'(IA_DIVISOR);
  assign ia_mag    = div_quot + 32'(ia_round);
  assign dev       = (delta_r >= ia_r) ? delta_r - ia_r : ia_r - delta_r;
  assign jit_diff  = (dev >= jit_r) ? dev - jit_r : jit_r - dev;
  assign jit_round = (32'(div_rem) + 32'(JIT_HALF)) >= 32'(JIT_DIVISOR);
  assign jit_mag   = div_quot + 32'(jit_round);
  assign elapsed   = item_r.arrival_time_us - last_adj_r;
  assign interval_us = 32'(cfg.interval) * 32'(MS_DIVISOR);
  assign sum_calc  = (SUM_W'(cfg.base_lat) << FRACTION_BITS) + SUM_W'(jit_r) +
                     (SUM_W'(jit_r) << 1) + (SUM_W'(1) << (FRACTION_BITS - 1));
  assign tgt_raw   = sum_r[SUM_W-1:FRACTION_BITS];
  assign tgt_lo    = (tgt_raw < TW'(cfg.min_lat)) ? TW'(cfg.min_lat) : tgt_raw;
  assign tgt_clamp = (tgt_lo > TW'(cfg.max_lat)) ? TW'(cfg.max_lat) : tgt_lo;
  assign lat_diff  = (target_r >= cur_lat_r) ? target_r - cur_lat_r : cur_lat_r - target_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    status_nxt   = status_r;
    cap_nxt      = cap_r;
    changed_nxt  = changed_r;
    seen_nxt     = seen_r;
    last_arr_nxt = last_arr_r;
    ia_nxt       = ia_r;
    jit_nxt      = jit_r;
    cur_lat_nxt  = cur_lat_r;
    last_adj_nxt = last_adj_r;
    capture_nxt  = capture_r;
    delta_nxt    = delta_r;
    up_nxt       = up_r;
    sum_nxt      = sum_r;
    target_nxt   = target_r;
    div_req      = '{start: 1'b0, op: DIV_MS};
    div_num      = '0;
    res_valid    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt  = chk_status;
        cap_nxt     = chk_cap;
        changed_nxt = 1'b0;
        if (chk_status != ST_OK) begin
          state_nxt = S_DONE;
        end else begin
          if (chk_cap) begin
            capture_nxt = item_r.header_bytes;
          end
          last_arr_nxt = item_r.arrival_time_us;
          if (!seen_r) begin
            seen_nxt  = 1'b1;
            state_nxt = S_ADJ_SUM;
          end else if (dus_sat) begin
            delta_nxt = 32'hFFFF_FFFF;
            state_nxt = S_IA_PREP;
          end else begin
            div_req   = '{start: 1'b1, op: DIV_MS};
            div_num   = dus;
            state_nxt = S_WAIT_SPLIT;
          end
        end
      end
      S_WAIT_SPLIT: begin
        if (div_done) begin
          delta_nxt = div_quot << SPLIT_SHIFT;
          div_req   = '{start: 1'b1, op: DIV_MS};
          div_num   = (32'(div_rem) << SPLIT_SHIFT) + 32'(MS_STEP_ROUND);
          state_nxt = S_WAIT_DELTA;
        end
      end
      S_WAIT_DELTA: begin
        if (div_done) begin
          delta_nxt = delta_r + div_quot;
          state_nxt = S_IA_PREP;
        end
      end
      S_IA_PREP: begin
        if (ia_r == 32'd0) begin
          ia_nxt    = delta_r;
          state_nxt = S_DEV_PREP;
        end else begin
          up_nxt    = delta_r >= ia_r;
          div_req   = '{start: 1'b1, op: DIV_IA};
          div_num   = ia_diff;
          state_nxt = S_WAIT_IA;
        end
      end
      S_WAIT_IA: begin
        if (div_done) begin
          ia_nxt    = up_r ? ia_r + ia_mag : ia_r - ia_mag;
          state_nxt = S_DEV_PREP;
        end
      end
      S_DEV_PREP: begin
        if (jit_r == 32'd0) begin
          jit_nxt   = dev;
          state_nxt = S_ADJ_SUM;
        end else begin
          up_nxt    = dev >= jit_r;
          div_req   = '{start: 1'b1, op: DIV_JIT};
          div_num   = jit_diff;
          state_nxt = S_WAIT_JIT;
        end
      end
      S_WAIT_JIT: begin
        if (div_done) begin
          jit_nxt   = up_r ? jit_r + jit_mag : jit_r - jit_mag;
          state_nxt = S_ADJ_SUM;
        end
      end
      S_ADJ_SUM: begin
        if (elapsed < interval_us) begin
          state_nxt = S_DONE;
        end else begin
          sum_nxt      = sum_calc;
          last_adj_nxt = item_r.arrival_time_us;
          state_nxt    = S_ADJ_CLAMP;
        end
      end
      S_ADJ_CLAMP: begin
        target_nxt = tgt_clamp[9:0];
        state_nxt  = S_ADJ_APPLY;
      end
      S_ADJ_APPLY: begin
        if (lat_diff >= cfg.threshold) begin
          cur_lat_nxt = target_r;
          changed_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg.init_load) begin
      cur_lat_nxt = cfg.init_lat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      seen_r     <= 1'b0;
      last_arr_r <= 32'd0;
      ia_r       <= 32'd0;
      jit_r      <= 32'd0;
      cur_lat_r  <= INIT_LAT_RST;
      last_adj_r <= 32'd0;
      capture_r  <= 64'd0;
    end else begin
      state_r    <= state_nxt;
      seen_r     <= seen_nxt;
      last_arr_r <= last_arr_nxt;
      ia_r       <= ia_nxt;
      jit_r      <= jit_nxt;
      cur_lat_r  <= cur_lat_nxt;
      last_adj_r <= last_adj_nxt;
      capture_r  <= capture_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    status_r  <= status_nxt;
    cap_r     <= cap_nxt;
    changed_r <= changed_nxt;
    delta_r   <= delta_nxt;
    up_r      <= up_nxt;
    sum_r     <= sum_nxt;
    target_r  <= target_nxt;
  end

  assign res.status               = status_r;
  assign res.capture_valid        = cap_r;
  assign res.capture_timestamp_us = capture_r;
  assign res.latency_ms           = cur_lat_r;
  assign res.latency_changed      = changed_r;
  assign res.jitter_estimate      = jit_r;

  a_accept_goes_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_CHECK)
    else $error("accepted word did not enter the header check");

  a_flags_need_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.latency_changed || res.capture_valid) |-> res.status == ST_OK)
    else $error("rejected word reports a capture or latency change");

  a_reject_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK && chk_status != ST_OK
    |=> $stable(ia_r) && $stable(jit_r) && $stable(last_arr_r) && $stable(capture_r))
    else $error("rejected word changed the averages");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_WAIT_SPLIT || state_r == S_WAIT_DELTA ||
                 state_r == S_WAIT_IA || state_r == S_WAIT_JIT)
    else $error("divider finished while the sequencer was not waiting");

endmodule

// ===== design/rtp_jitter_latency_adapter.sv =====
// Top level of the RTP jitter latency adapter with its result register.
`timescale 1ns / 1ps

// One packet header enters per input word and one result word leaves for it.
// A rejected packet goes from the header check straight to its result, and
// the first accepted packet goes straight to the latency interval check, then
// through the sum, clamp and apply steps when the interval has elapsed. Every
// later accepted packet goes through one shared divider by a small constant,
// which multiplies by a rounded-down reciprocal and corrects the quotient by
// one: two divisions turn the arrival gap into milliseconds (both skipped when
// the gap saturates), then one for each average that is not loaded directly.
// The same edge that loads the result returns the sequencer to idle, so the
// input is ready again once the result is loaded; the sequencer holds its
// result while the output register still carries an unaccepted word.
module rtp_jitter_latency_adapter import rtpjla_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // arrival_time_us[31:0], packet_length[47:32], type_byte[55:48],
  // header_bytes[119:56], ninth_byte[127:120]
  input  logic [127:0]          in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // capture_timestamp_us[63:0], latency_ms[73:64], latency_changed[74],
  // jitter_estimate[106:75], zero[111:107]
  output logic [111:0]          out_tdata,
  // status[1:0], capture_valid[2]
  output logic [2:0]            out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t     cfg;
  in_item_t in_item;
  res_t     res;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid_r, out_valid_nxt;
  res_t     out_res_r, out_res_nxt;

  rtpjla_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_item.arrival_time_us = in_tdata[31:0];
  assign in_item.packet_length   = in_tdata[47:32];
  assign in_item.type_byte       = in_tdata[55:48];
  assign in_item.header_bytes    = in_tdata[119:56];
  assign in_item.ninth_byte      = in_tdata[127:120];

  rtpjla_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.jitter_estimate, out_res_r.latency_changed,
                       out_res_r.latency_ms, out_res_r.capture_timestamp_us};
  assign out_tuser  = {out_res_r.capture_valid, out_res_r.status};

endmodule
